@@ sv/axis_rotation_matrix_row_macros.svh @@
// Assertion macros for the row rotation block.
// Used by the top level only; depends on nothing.
`ifndef AXIS_ROTATION_MATRIX_ROW_MACROS_SVH
`define AXIS_ROTATION_MATRIX_ROW_MACROS_SVH

// same-cycle implication
`define ARMR_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("armr same-cycle check failed");

// next-cycle implication
`define ARMR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("armr next-cycle check failed");

`endif

@@ sv/armr_pkg.sv @@
// Shared constants, types and tables for the row rotation block.
// No dependencies; imported by every other file except the assertion macros header.
package armr_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int TRIG_FRAC      = 24;
   localparam int TRIG_W         = TRIG_FRAC + 2;
   localparam int PHASE_W        = 32;
   localparam int CORDIC_STEPS   = 30;
   localparam int CORDIC_W       = PHASE_W + 2;
   localparam int Z_W            = PHASE_W + 1;
   localparam int RND_SHIFT      = 30 - TRIG_FRAC;
   localparam int CORDIC_LAT     = CORDIC_STEPS + 1;
   localparam int LANE_LAT       = 3;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [PHASE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_v;
      logic signed [TRIG_W-1:0] sin_v;
      logic signed [TRIG_W-1:0] nsin_v;
   } trig_type;

   typedef struct packed {
      logic is_x;
      logic is_y;
      logic is_z;
   } axis_sel_type;

   function automatic axis_sel_type axis_decode(input logic [1:0] code);
      axis_sel_type sel;
      sel = '0;
      unique case (code)
         AXIS_X:  sel.is_x = 1'b1;
         AXIS_Y:  sel.is_y = 1'b1;
         default: sel.is_z = 1'b1;
      endcase
      return sel;
   endfunction

endpackage

@@ sv/armr_if.sv @@
// Valid/ready stream interfaces for the request and response channels.
// Depends on armr_pkg for default widths.
interface armr_req_if import armr_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] in_c0;
   logic signed [ELEM_WIDTH-1:0] in_c1;
   logic signed [ELEM_WIDTH-1:0] in_c2;
   logic signed [ELEM_WIDTH-1:0] in_c3;
   logic [ANGLE_BITS-1:0]        rot_angle;
   logic [1:0]                   rot_axis;

   modport source (output valid, in_c0, in_c1, in_c2, in_c3, rot_angle, rot_axis,
                   input ready);
   modport sink (input valid, in_c0, in_c1, in_c2, in_c3, rot_angle, rot_axis,
                 output ready);
endinterface

interface armr_rsp_if import armr_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] out_c0;
   logic signed [ELEM_WIDTH-1:0] out_c1;
   logic signed [ELEM_WIDTH-1:0] out_c2;
   logic signed [ELEM_WIDTH-1:0] out_c3;

   modport source (output valid, out_c0, out_c1, out_c2, out_c3, input ready);
   modport sink (input valid, out_c0, out_c1, out_c2, out_c3, output ready);
endinterface

@@ sv/armr_cordic.sv @@
// Pipelined rotation-mode CORDIC: one iteration per stage, then rounding to Q1.24.
// Depends on armr_pkg (atan table, gain, trig_type).
module armr_cordic import armr_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output trig_type              trig
);

   localparam int TRIG_RW = CORDIC_W - RND_SHIFT;
   localparam int LAST    = CORDIC_STEPS - 1;
   localparam logic signed [CORDIC_W-1:0] ROUND_HALF = CORDIC_W'(1) <<< (RND_SHIFT - 1);
   localparam logic signed [TRIG_RW-1:0]  ONE_R      = TRIG_RW'(1) <<< TRIG_FRAC;
   localparam logic signed [TRIG_W-1:0]   ONE_T      = TRIG_W'(1) <<< TRIG_FRAC;

   logic [PHASE_W-1:0]         phase;
   logic                       flip;
   logic signed [Z_W-1:0]      z_start;

   logic signed [CORDIC_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [Z_W-1:0]      z_ff [CORDIC_STEPS];
   logic                       flip_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x_in [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_in [CORDIC_STEPS];
   logic signed [Z_W-1:0]      z_in [CORDIC_STEPS];
   logic                       flip_in [CORDIC_STEPS];

   logic signed [CORDIC_W-1:0] cos_sum, sin_sum;
   logic signed [TRIG_RW-1:0]  cos_rnd, sin_rnd;
   logic signed [TRIG_W-1:0]   cos_clp, sin_clp;
   trig_type                   trig_in, trig_ff;

   function automatic logic signed [TRIG_W-1:0] clamp_trig(
      input logic signed [TRIG_RW-1:0] v
   );
      logic signed [TRIG_W-1:0] res;
      if (v > ONE_R) begin
         res = ONE_T;
      end else if (v < -ONE_R) begin
         res = -ONE_T;
      end else begin
         res = v[TRIG_W-1:0];
      end
      return res;
   endfunction

   // fold the second and third quadrants by a half turn
   assign phase   = {angle, {(PHASE_W - ANGLE_BITS){1'b0}}};
   assign flip    = phase[PHASE_W-1] ^ phase[PHASE_W-2];
   assign z_start = {{2{phase[PHASE_W-1] ^ flip}}, phase[PHASE_W-2:0]};

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] x_cur, y_cur, dx, dy;
      logic signed [Z_W-1:0]      z_cur, atan_v;
      logic                       f_cur;
      if (i == 0) begin : g_first
         assign x_cur = CORDIC_GAIN;
         assign y_cur = '0;
         assign z_cur = z_start;
         assign f_cur = flip;
      end else begin : g_rest
         assign x_cur = x_ff[i-1];
         assign y_cur = y_ff[i-1];
         assign z_cur = z_ff[i-1];
         assign f_cur = flip_ff[i-1];
      end
      assign dx         = y_cur >>> i;
      assign dy         = x_cur >>> i;
      assign atan_v     = $signed({1'b0, ATAN_TAB[i]});
      assign x_in[i]    = z_cur[Z_W-1] ? x_cur + dx : x_cur - dx;
      assign y_in[i]    = z_cur[Z_W-1] ? y_cur - dy : y_cur + dy;
      assign z_in[i]    = z_cur[Z_W-1] ? z_cur + atan_v : z_cur - atan_v;
      assign flip_in[i] = f_cur;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            flip_ff[k] <= flip_in[k];
         end
      end
   end

   // round half up to Q1.24, clamp, undo the fold
   always_comb begin
      cos_sum        = x_ff[LAST] + ROUND_HALF;
      sin_sum        = y_ff[LAST] + ROUND_HALF;
      cos_rnd        = cos_sum[CORDIC_W-1:RND_SHIFT];
      sin_rnd        = sin_sum[CORDIC_W-1:RND_SHIFT];
      cos_clp        = clamp_trig(cos_rnd);
      sin_clp        = clamp_trig(sin_rnd);
      trig_in.cos_v  = flip_ff[LAST] ? -cos_clp : cos_clp;
      trig_in.sin_v  = flip_ff[LAST] ? -sin_clp : sin_clp;
      trig_in.nsin_v = flip_ff[LAST] ? sin_clp : -sin_clp;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

@@ sv/armr_lane.sv @@
// Mixing lane: r = round_half_up((a*p + b*q) / 2^24), saturated, in three stages.
// Depends on armr_pkg for trig widths.
module armr_lane import armr_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [ELEM_WIDTH-1:0] a,
   input  logic signed [ELEM_WIDTH-1:0] b,
   input  logic signed [TRIG_W-1:0]     p,
   input  logic signed [TRIG_W-1:0]     q,
   output logic signed [ELEM_WIDTH-1:0] r
);

   localparam int XW  = (ELEM_WIDTH > TRIG_FRAC) ? ELEM_WIDTH : TRIG_FRAC + 1;
   localparam int AHW = XW - TRIG_FRAC;
   localparam int ALW = TRIG_FRAC + 1;
   localparam int HPW = AHW + TRIG_W;
   localparam int LPW = ALW + TRIG_W;
   localparam int HW  = HPW + 1;
   localparam int LW  = LPW + 1;
   localparam int LSW = LW - TRIG_FRAC;
   localparam int SW  = ((HW > LSW) ? HW : LSW) + 1;
   localparam int TW  = SW - ELEM_WIDTH + 1;
   localparam logic signed [LW-1:0] LO_HALF = LW'(1) <<< (TRIG_FRAC - 1);
   localparam logic signed [ELEM_WIDTH-1:0] SAT_MAX = {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
   localparam logic signed [ELEM_WIDTH-1:0] SAT_MIN = {1'b1, {(ELEM_WIDTH - 1){1'b0}}};

   logic signed [XW-1:0]         a_x, b_x;
   logic signed [AHW-1:0]        a_hi, b_hi;
   logic signed [ALW-1:0]        a_lo, b_lo;
   logic signed [HPW-1:0]        ahp_in, bhq_in, ahp_ff, bhq_ff;
   logic signed [LPW-1:0]        alp_in, blq_in, alp_ff, blq_ff;
   logic signed [HW-1:0]         hi_in, hi_ff;
   logic signed [LW-1:0]         lo_in, lo_ff;
   logic signed [LSW-1:0]        lo_sh;
   logic signed [SW-1:0]         sum;
   logic [TW-1:0]                top;
   logic signed [ELEM_WIDTH-1:0] r_in, r_ff;

   // split each operand at the trig fraction to keep the multipliers narrow
   always_comb begin
      a_x    = XW'(a);
      b_x    = XW'(b);
      a_hi   = $signed(a_x[XW-1:TRIG_FRAC]);
      b_hi   = $signed(b_x[XW-1:TRIG_FRAC]);
      a_lo   = $signed({1'b0, a_x[TRIG_FRAC-1:0]});
      b_lo   = $signed({1'b0, b_x[TRIG_FRAC-1:0]});
      ahp_in = HPW'(a_hi * p);
      bhq_in = HPW'(b_hi * q);
      alp_in = LPW'(a_lo * p);
      blq_in = LPW'(b_lo * q);
   end

   always_comb begin
      hi_in = HW'(ahp_ff) + HW'(bhq_ff);
      lo_in = LW'(alp_ff) + LW'(blq_ff) + LO_HALF;
   end

   always_comb begin
      lo_sh = $signed(lo_ff[LW-1:TRIG_FRAC]);
      sum   = SW'(hi_ff) + SW'(lo_sh);
      top   = sum[SW-1:ELEM_WIDTH-1];
      if ((&top) || !(|top)) begin
         r_in = sum[ELEM_WIDTH-1:0];
      end else if (sum[SW-1]) begin
         r_in = SAT_MIN;
      end else begin
         r_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ahp_ff <= ahp_in;
         bhq_ff <= bhq_in;
         alp_ff <= alp_in;
         blq_ff <= blq_in;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         r_ff   <= r_in;
      end
   end

   assign r = r_ff;

endmodule

@@ sv/armr_merge.sv @@
// Merge stage: places the two lane results by axis and holds the response register.
// Depends on armr_pkg (axis_sel_type).
module armr_merge import armr_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  axis_sel_type                 sel,
   input  logic signed [ELEM_WIDTH-1:0] e0,
   input  logic signed [ELEM_WIDTH-1:0] e1,
   input  logic signed [ELEM_WIDTH-1:0] e2,
   input  logic signed [ELEM_WIDTH-1:0] e3,
   input  logic signed [ELEM_WIDTH-1:0] ra,
   input  logic signed [ELEM_WIDTH-1:0] rb,
   output logic signed [ELEM_WIDTH-1:0] out0,
   output logic signed [ELEM_WIDTH-1:0] out1,
   output logic signed [ELEM_WIDTH-1:0] out2,
   output logic signed [ELEM_WIDTH-1:0] out3
);

   logic signed [ELEM_WIDTH-1:0] o0_in, o1_in, o2_in;
   logic signed [ELEM_WIDTH-1:0] o0_ff, o1_ff, o2_ff, o3_ff;

   always_comb begin
      o0_in = sel.is_x ? e0 : ra;
      o1_in = sel.is_x ? ra : (sel.is_z ? rb : e1);
      o2_in = sel.is_z ? e2 : rb;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         o0_ff <= o0_in;
         o1_ff <= o1_in;
         o2_ff <= o2_in;
         o3_ff <= e3;
      end
   end

   assign out0 = o0_ff;
   assign out1 = o1_ff;
   assign out2 = o2_ff;
   assign out3 = o3_ff;

endmodule

@@ sv/axis_rotation_matrix_row.sv @@
// Channel   Dir  Handshake    Payload
// req_bus   in   valid/ready  in_c0..in_c3, rot_angle, rot_axis
// rsp_bus   out  valid/ready  out_c0..out_c3
//
// One request per cycle while the pipeline is not held; a response passes, in order, through
// 30 CORDIC stages, one trig rounding stage, three lane stages and the response register.
// The full pipeline moves as one; it holds only while the response waits and the
// last stage is full, so requests keep flowing into empty slots behind a stall.
// Reset clears the valid bits only; nothing is kept from one request to the next.
`include "axis_rotation_matrix_row_macros.svh"

module axis_rotation_matrix_row import armr_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   armr_req_if.sink   req_bus,
   armr_rsp_if.source rsp_bus
);

   localparam int DEPTH    = CORDIC_LAT + LANE_LAT;
   localparam int TAP_LANE = CORDIC_LAT - 1;
   localparam int ROW_W    = 4 * ELEM_WIDTH + 2;

   logic                         en, load;
   logic                         rsp_stall;
   logic [DEPTH-1:0]             vld_in, vld_ff;
   logic                         rsp_valid_ff;
   logic [ROW_W-1:0]             row_in;
   logic [ROW_W-1:0]             row_ff [DEPTH];
   logic [ROW_W-1:0]             ln_row, mg_row;
   trig_type                     trig;
   axis_sel_type                 ln_sel, mg_sel;
   logic signed [ELEM_WIDTH-1:0] ln_e0, ln_e1, ln_e2;
   logic signed [ELEM_WIDTH-1:0] mg_e0, mg_e1, mg_e2, mg_e3;
   logic signed [ELEM_WIDTH-1:0] op_a, op_b, ra, rb;
   logic signed [TRIG_W-1:0]     pa, qa, pb, qb;

   assign load          = rsp_bus.ready || !rsp_valid_ff;
   assign en            = load || !vld_ff[DEPTH-1];
   assign rsp_stall     = rsp_valid_ff && !rsp_bus.ready;
   assign req_bus.ready = en;
   assign rsp_bus.valid = rsp_valid_ff;

   assign vld_in = {vld_ff[DEPTH-2:0], req_bus.valid};
   assign row_in = {req_bus.rot_axis, req_bus.in_c3, req_bus.in_c2,
                    req_bus.in_c1, req_bus.in_c0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         if (load) begin
            rsp_valid_ff <= vld_ff[DEPTH-1];
         end
      end
   end

   // row elements and axis ride alongside the datapath
   always_ff @(posedge clock) begin
      if (en) begin
         row_ff[0] <= row_in;
         for (int k = 1; k < DEPTH; k++) begin
            row_ff[k] <= row_ff[k-1];
         end
      end
   end

   armr_cordic #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_cordic (
      .clock(clock),
      .en   (en),
      .angle(req_bus.rot_angle),
      .trig (trig)
   );

   // pick lane operands by axis
   always_comb begin
      ln_row = row_ff[TAP_LANE];
      ln_e0  = $signed(ln_row[ELEM_WIDTH-1:0]);
      ln_e1  = $signed(ln_row[2*ELEM_WIDTH-1:ELEM_WIDTH]);
      ln_e2  = $signed(ln_row[3*ELEM_WIDTH-1:2*ELEM_WIDTH]);
      ln_sel = axis_decode(ln_row[ROW_W-1:ROW_W-2]);
      op_a   = ln_sel.is_x ? ln_e1 : ln_e0;
      op_b   = ln_sel.is_z ? ln_e1 : ln_e2;
      pa     = trig.cos_v;
      qa     = ln_sel.is_y ? trig.nsin_v : trig.sin_v;
      pb     = ln_sel.is_y ? trig.sin_v : trig.nsin_v;
      qb     = trig.cos_v;
   end

   armr_lane #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_lane_a (
      .clock(clock),
      .en   (en),
      .a    (op_a),
      .b    (op_b),
      .p    (pa),
      .q    (qa),
      .r    (ra)
   );

   armr_lane #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_lane_b (
      .clock(clock),
      .en   (en),
      .a    (op_a),
      .b    (op_b),
      .p    (pb),
      .q    (qb),
      .r    (rb)
   );

   always_comb begin
      mg_row = row_ff[DEPTH-1];
      mg_e0  = $signed(mg_row[ELEM_WIDTH-1:0]);
      mg_e1  = $signed(mg_row[2*ELEM_WIDTH-1:ELEM_WIDTH]);
      mg_e2  = $signed(mg_row[3*ELEM_WIDTH-1:2*ELEM_WIDTH]);
      mg_e3  = $signed(mg_row[4*ELEM_WIDTH-1:3*ELEM_WIDTH]);
      mg_sel = axis_decode(mg_row[ROW_W-1:ROW_W-2]);
   end

   armr_merge #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_merge (
      .clock(clock),
      .load (load),
      .sel  (mg_sel),
      .e0   (mg_e0),
      .e1   (mg_e1),
      .e2   (mg_e2),
      .e3   (mg_e3),
      .ra   (ra),
      .rb   (rb),
      .out0 (rsp_bus.out_c0),
      .out1 (rsp_bus.out_c1),
      .out2 (rsp_bus.out_c2),
      .out3 (rsp_bus.out_c3)
   );

   `ARMR_ASSERT_NEXT(a_accept_enters, clock, reset, req_bus.valid && req_bus.ready, vld_ff[0])
   `ARMR_ASSERT_IMPLY(a_hold_full, clock, reset, !req_bus.ready, rsp_stall && vld_ff[DEPTH-1])
   `ARMR_ASSERT_NEXT(a_last_delivered, clock, reset, vld_ff[DEPTH-1] && load, rsp_valid_ff)

endmodule
